FILE: design/assert_macros.svh
// Assertion macros shared by the filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Condition that holds on every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`endif

FILE: design/fpiir_pkg.sv
// Package with types, constants and helpers for the transposed IIR filter.
package fpiir_pkg;
	localparam int MAX_TAPS = 8;
	localparam int NDLY = MAX_TAPS - 1;
	localparam int DLY_IW = $clog2(NDLY);
	localparam int ACC_W = 64;
	localparam int PROD_W = 49;
	localparam int MUL_CYC = 16;
	localparam int CNT_W = $clog2(MUL_CYC + 1);

	typedef enum logic [2:0] {
		REG_FF_LOW  = 3'd0,
		REG_FF_HIGH = 3'd1,
		REG_FB_LOW  = 3'd2,
		REG_FB_HIGH = 3'd3,
		REG_TAPS    = 3'd4,
		REG_SHIFT   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic [15:0] mcand;
		logic [31:0] mplier;
	} mul_cmd_t;

	typedef struct packed {
		logic done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

	function automatic logic wraps32(input logic signed [ACC_W-1:0] v);
		return (v[ACC_W-1:31] != '0) && (v[ACC_W-1:31] != '1);
	endfunction
endpackage

FILE: design/fpiir_serial_mul.sv
// Two-bit-per-cycle signed multiplier: 16-bit coefficient times 32-bit value.
module fpiir_serial_mul (
	input  logic clk,
	input  logic arst_n,
	input  fpiir_pkg::mul_cmd_t cmd,
	output fpiir_pkg::mul_rsp_t rsp
);
	import fpiir_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [31:0] mplier_q;
	logic signed [15:0] mcand_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] mc_ext;
	logic signed [PROD_W-1:0] mq_ext;
	logic signed [PROD_W-1:0] p0, p1;
	logic [5:0] sh;
	logic last;

	assign mc_ext = PROD_W'(signed'(cmd.mcand));
	assign last = (cnt_q == CNT_W'(MUL_CYC - 1));
	assign mq_ext = PROD_W'(mcand_q);
	assign sh = {1'b0, cnt_q[CNT_W-2:0], 1'b0};
	assign rsp = '{done: done_q, prod: prod_q};

	always_comb begin
		p0 = mplier_q[0] ? (mq_ext <<< sh) : '0;
		p1 = mplier_q[1] ? (mq_ext <<< (sh + 6'd1)) : '0;
		if (last && mplier_q[1])
			p1 = -(mq_ext <<< (sh + 6'd1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mcand_q <= mc_ext[15:0];
			mplier_q <= cmd.mplier;
			acc_q <= '0;
		end else if (busy_q) begin
			mplier_q <= {2'b00, mplier_q[31:2]};
			acc_q <= acc_q + p0 + p1;
			if (last)
				prod_q <= acc_q + p0 + p1;
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_done_one_cycle, rsp.done, !$past(rsp.done), "multiplier done held")
	`ASSERT_IMPL(a_no_restart, busy_q && !last, !rsp.done, "early multiplier done")
	`ASSERT_ALWAYS(a_cnt_range, cnt_q < CNT_W'(MUL_CYC), "multiplier count out of range")
endmodule

FILE: design/fpiir_core.sv
// Sequencer that evaluates the output and delay updates with one shared multiplier.
module fpiir_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [15:0] sample,
	input  logic [63:0] ff_lo,
	input  logic [63:0] ff_hi,
	input  logic [63:0] fb_lo,
	input  logic [47:0] fb_hi,
	input  logic [3:0] taps,
	input  logic [4:0] qsh,
	output logic busy,
	output logic done,
	output logic signed [31:0] y_out,
	output logic ovf_out
);
	import fpiir_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_BX, S_Y, S_AY, S_UPD} state_t;
	state_t state_q;

	logic [31:0] dly_q [NDLY];
	logic [2:0] k_q;
	logic [2:0] n_m1;
	logic signed [15:0] x_q;
	logic signed [ACC_W-1:0] y_q, acc_q;
	logic signed [PROD_W-1:0] bx_q;
	logic ovf_q;
	mul_cmd_t cmd;
	mul_rsp_t rsp;

	logic [127:0] bvec;
	logic [111:0] avec;
	logic signed [15:0] b_k, a_k;
	logic signed [ACC_W-1:0] dterm, sum, shifted;
	logic [2:0] kn;
	logic use_d;

	always_comb begin
		if (taps < 4'd2) n_m1 = 3'd1;
		else if (taps > 4'(MAX_TAPS)) n_m1 = 3'(MAX_TAPS - 1);
		else n_m1 = 3'(taps - 4'd1);
	end

	assign bvec = {ff_hi, ff_lo};
	assign avec = {fb_hi, fb_lo};
	assign b_k = bvec[16*k_q +: 16];
	assign a_k = avec[16*(k_q - 3'd1) +: 16];
	assign kn = k_q;
	assign use_d = (k_q < n_m1) && (k_q != 3'd0 || state_q == S_Y);
	always_comb begin
		dterm = use_d ? (ACC_W'(signed'(dly_q[kn[DLY_IW-1:0]])) <<< qsh) : '0;
		sum = ACC_W'(bx_q) - ((state_q == S_AY) ? ACC_W'(rsp.prod) : '0) + dterm;
		if (state_q == S_Y)
			sum = ACC_W'(rsp.prod) + dterm;
		shifted = sum >>> qsh;
	end

	always_comb begin
		cmd.start = 1'b0;
		cmd.mcand = bvec[16*(k_q + 3'd1) +: 16];
		cmd.mplier = 32'(x_q);
		case (state_q)
			S_IDLE: begin
				cmd.start = start;
				cmd.mcand = bvec[15:0];
				cmd.mplier = 32'(sample);
			end
			S_Y: cmd.start = rsp.done;
			S_BX: begin
				cmd.start = rsp.done;
				cmd.mcand = a_k;
				cmd.mplier = y_q[31:0];
			end
			S_UPD: cmd.start = (k_q < n_m1);
			default: ;
		endcase
	end

	fpiir_serial_mul u_mul (.clk(clk), .arst_n(arst_n), .cmd(cmd), .rsp(rsp));

	// The product a*y uses the low 32 bits of y, read as signed, as multiplier; the rest
	// of y is a small multiple of 2^32 that is added back so the exact product is kept.
	logic [ACC_W-1:0] y_rnd;
	logic signed [17:0] ay_hi;
	logic signed [ACC_W-1:0] ay_full;
	assign y_rnd = y_q + 64'h0000_0000_8000_0000;
	assign ay_hi = a_k * signed'(y_rnd[33:32]);
	assign ay_full = ACC_W'(rsp.prod) + (ACC_W'(ay_hi) <<< 32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q <= '0;
			done <= 1'b0;
			x_q <= '0;
			y_q <= '0;
			acc_q <= '0;
			bx_q <= '0;
			ovf_q <= 1'b0;
			y_out <= '0;
			ovf_out <= 1'b0;
			for (int i = 0; i < NDLY; i++)
				dly_q[i] <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q <= '0;
						x_q <= sample;
						ovf_q <= 1'b0;
						state_q <= S_Y;
					end
				end
				S_Y: begin
					if (rsp.done) begin
						y_q <= shifted;
						ovf_q <= wraps32(shifted);
						k_q <= 3'd1;
						state_q <= S_BX;
					end
				end
				S_BX: begin
					if (rsp.done) begin
						bx_q <= rsp.prod;
						state_q <= S_AY;
					end
				end
				S_AY: begin
					if (rsp.done) begin
						acc_q <= (ACC_W'(bx_q) - ay_full + dterm) >>> qsh;
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					dly_q[3'(k_q - 3'd1)] <= acc_q[31:0];
					if (wraps32(acc_q))
						ovf_q <= 1'b1;
					if (k_q == n_m1) begin
						done <= 1'b1;
						y_out <= y_q[31:0];
						ovf_out <= ovf_q | wraps32(acc_q);
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 3'd1;
						state_q <= S_BX;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	`include "assert_macros.svh"
	`ASSERT_IMPL(a_start_idle, start, state_q == S_IDLE, "start while busy")
	`ASSERT_IMPL(a_done_idle, done, state_q == S_IDLE, "done outside idle")
	`ASSERT_ALWAYS(a_k_range, k_q <= 3'(MAX_TAPS - 1), "tap index out of range")
endmodule

FILE: design/fixed_point_iir_transposed.sv
// Top level of the fixed-point transposed direct form II IIR filter.
// channel | direction | contents
// s_axis  | in        | tdata[15:0] sample
// m_axis  | out       | tdata[31:0] filtered, tuser[0] overflow
// cfg     | in        | cfg_index[2:0] register, cfg_data[63:0] value
// m_axis_tvalid rises once the output and all n-1 delay updates of a sample are done,
// n being the taps clamped to 2..8. The shared two-bit serial multiplier computes
// every product; the output takes one product and each of the n-1 delay updates two
// plus a write state.
// Reset clears the registers to their defaults and the delay line to zero.
// A result waits in the output register while m_axis_tready is low; a new
// sample is taken only once the previous result has been handed over.
module fixed_point_iir_transposed (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [15:0] s_axis_tdata, // sample
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [31:0] m_axis_tdata, // filtered
	output logic [0:0] m_axis_tuser, // overflow
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data
);
	import fpiir_pkg::*;

	logic [63:0] ff_lo_q, ff_hi_q, fb_lo_q;
	logic [47:0] fb_hi_q;
	logic [3:0] taps_q;
	logic [4:0] shift_q;
	logic busy, done, ovf, s_acc;
	logic signed [31:0] y;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !busy && !m_axis_tvalid && !done;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_lo_q <= '0;
			ff_hi_q <= '0;
			fb_lo_q <= '0;
			fb_hi_q <= '0;
			taps_q <= 4'd2;
			shift_q <= 5'd15;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_FF_LOW: ff_lo_q <= cfg_data;
					REG_FF_HIGH: ff_hi_q <= cfg_data;
					REG_FB_LOW: fb_lo_q <= cfg_data;
					REG_FB_HIGH: fb_hi_q <= cfg_data[47:0];
					REG_TAPS: taps_q <= cfg_data[3:0];
					REG_SHIFT: shift_q <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (done)
				m_axis_tvalid <= 1'b1;
			else if (m_axis_tready)
				m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_axis_tdata <= y;
			m_axis_tuser <= ovf;
		end
	end

	fpiir_core u_core (
		.clk(clk), .arst_n(arst_n), .start(s_acc), .sample(s_axis_tdata),
		.ff_lo(ff_lo_q), .ff_hi(ff_hi_q), .fb_lo(fb_lo_q), .fb_hi(fb_hi_q),
		.taps(taps_q), .qsh(shift_q), .busy(busy), .done(done),
		.y_out(y), .ovf_out(ovf)
	);
endmodule
